// ===== src/axt_pkg.sv =====
package axt_pkg;

	localparam int NUM_REGS = 32;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W = 64;
	localparam int INSN_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_REG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE = 1'd1;

	// Result status codes.
	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_HIT = 2'd1;
	localparam logic [1:0] STATUS_END = 2'd2;

	// Instruction decode patterns.
	localparam logic [INSN_W-1:0] OP_RET = 32'hD65F03C0;
	localparam logic [INSN_W-1:0] MASK_LDRLIT = 32'hFF000000;
	localparam logic [INSN_W-1:0] PAT_LDRLIT = 32'h58000000;
	localparam logic [INSN_W-1:0] MASK_ADR = 32'h9F000000;
	localparam logic [INSN_W-1:0] PAT_ADR = 32'h10000000;
	localparam logic [INSN_W-1:0] PAT_ADRP = 32'h90000000;
	localparam logic [INSN_W-1:0] MASK_ADDLDR = 32'hFFC00000;
	localparam logic [INSN_W-1:0] PAT_ADD = 32'h91000000;
	localparam logic [INSN_W-1:0] PAT_LDRUOFF = 32'hF9400000;
	localparam logic [ADDR_W-1:0] PAGE_MASK = 64'hFFF;

endpackage

// ===== src/axt_in_if.sv =====
interface axt_in_if;
	logic valid;
	logic ready;
	logic [axt_pkg::INSN_W-1:0] insn;
	logic [axt_pkg::ADDR_W-1:0] pc;
	logic last;

	modport source (output valid, output insn, output pc, output last, input ready);
	modport sink (input valid, input insn, input pc, input last, output ready);
endinterface

// ===== src/axt_out_if.sv =====
interface axt_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [axt_pkg::ADDR_W-1:0] value;

	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);
endinterface

// ===== src/axt_cfg_if.sv =====
interface axt_cfg_if;
	logic valid;
	logic ready;
	logic [axt_pkg::CFG_IDX_W-1:0] index;
	logic [axt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/arm64_address_xref_tracker.sv =====
// ARM64 address cross-reference tracker.
// The item channel carries one instruction word with its address and a last
// flag; every accepted word gives exactly one word on the result channel
// (status and value). The cfg channel writes target_reg (index 0) and
// target_value (index 1); it is always ready. The user must write it only
// while idle; the block does not enforce it. The block takes one item per
// cycle unless the receiver stalls: the tracked register file is a memory
// with two registered read ports (base and destination registers), read
// when the item is accepted and written back as it leaves stage 1, with a
// bypass for a write on the read edge. Each entry has a valid bit in
// flip-flops, so RET and the end of a scan clear the whole file at once.
// Reset clears the valid bits, the hit flag, the configuration registers and
// the pipeline; the block can take an item in the first cycle after reset.
// When the receiver stalls, the result register holds its word, the stage
// behind it holds its item, and item.ready drops once both are full.
module arm64_address_xref_tracker (
	input logic clk,
	input logic arst_n,
	axt_in_if.sink item,
	axt_out_if.source result,
	axt_cfg_if.sink cfg
);

	logic [axt_pkg::REG_IDX_W-1:0] target_reg_q;
	logic [axt_pkg::ADDR_W-1:0] target_value_q;

	logic [axt_pkg::ADDR_W-1:0] reg_mem [axt_pkg::NUM_REGS];
	logic [axt_pkg::NUM_REGS-1:0] valid_q;
	logic hit_seen_q;

	logic v_s1;
	logic [axt_pkg::INSN_W-1:0] insn_s1;
	logic [axt_pkg::ADDR_W-1:0] pc_s1;
	logic last_s1;
	logic [axt_pkg::ADDR_W-1:0] rn_rd_s1;
	logic [axt_pkg::ADDR_W-1:0] rd_rd_s1;
	logic rn_fwd_s1;
	logic rd_fwd_s1;
	logic [axt_pkg::ADDR_W-1:0] fwd_data_s1;

	logic out_v_q;
	logic [1:0] out_status_q;
	logic [axt_pkg::ADDR_W-1:0] out_value_q;

	logic s1_adv;
	logic accept;
	logic [axt_pkg::REG_IDX_W-1:0] rn_in;
	logic [axt_pkg::REG_IDX_W-1:0] rn;
	logic [axt_pkg::REG_IDX_W-1:0] rd;
	logic [11:0] imm12;
	logic [20:0] imm21;
	logic is_ldrlit, is_adr, is_adrp, is_add, is_ldr, is_ret;
	logic do_wr;
	logic mem_we;
	logic [axt_pkg::ADDR_W-1:0] rn_val;
	logic [axt_pkg::ADDR_W-1:0] rd_val;
	logic [axt_pkg::ADDR_W-1:0] base;
	logic [axt_pkg::ADDR_W-1:0] offs;
	logic [axt_pkg::ADDR_W-1:0] new_val;
	logic [axt_pkg::ADDR_W-1:0] check_val;
	logic hit;
	logic [1:0] status;
	logic [axt_pkg::ADDR_W-1:0] value;

	assign cfg.ready = 1'b1;

	assign s1_adv = v_s1 && (!out_v_q || result.ready);
	assign item.ready = !v_s1 || s1_adv;
	assign accept = item.valid && item.ready;
	assign rn_in = item.insn[9:5];

	// Decode of the item in stage 1.
	assign rd = insn_s1[4:0];
	assign rn = insn_s1[9:5];
	assign imm12 = insn_s1[21:10];
	assign imm21 = {insn_s1[23:5], insn_s1[30:29]};
	assign is_ldrlit = (insn_s1 & axt_pkg::MASK_LDRLIT) == axt_pkg::PAT_LDRLIT;
	assign is_adr = (insn_s1 & axt_pkg::MASK_ADR) == axt_pkg::PAT_ADR;
	assign is_adrp = (insn_s1 & axt_pkg::MASK_ADR) == axt_pkg::PAT_ADRP;
	assign is_add = (insn_s1 & axt_pkg::MASK_ADDLDR) == axt_pkg::PAT_ADD;
	assign is_ldr = (insn_s1 & axt_pkg::MASK_ADDLDR) == axt_pkg::PAT_LDRUOFF;
	assign is_ret = insn_s1 == axt_pkg::OP_RET;
	assign do_wr = is_ldrlit || is_adr || is_adrp || is_add || is_ldr;
	assign mem_we = s1_adv && !hit_seen_q && do_wr;

	// An invalid entry reads as zero; a write on the read edge is bypassed.
	assign rn_val = !valid_q[rn] ? '0 : (rn_fwd_s1 ? fwd_data_s1 : rn_rd_s1);
	assign rd_val = !valid_q[rd] ? '0 : (rd_fwd_s1 ? fwd_data_s1 : rd_rd_s1);

	always_comb begin
		base = rn_val;
		offs = {{(axt_pkg::ADDR_W-12){1'b0}}, imm12};
		if (is_ldrlit) begin
			base = pc_s1;
			offs = {{(axt_pkg::ADDR_W-21){insn_s1[23]}}, insn_s1[23:5], 2'b00};
		end else if (is_adr) begin
			base = pc_s1;
			offs = {{(axt_pkg::ADDR_W-21){imm21[20]}}, imm21};
		end else if (is_adrp) begin
			base = pc_s1 & ~axt_pkg::PAGE_MASK;
			offs = {{(axt_pkg::ADDR_W-33){imm21[20]}}, imm21, 12'h000};
		end else if (is_ldr) begin
			offs = {{(axt_pkg::ADDR_W-15){1'b0}}, imm12, 3'b000};
		end
	end

	assign new_val = base + offs;

	always_comb begin
		if (do_wr) begin
			check_val = new_val;
		end else if (is_ret) begin
			check_val = '0;
		end else begin
			check_val = rd_val;
		end
	end

	always_comb begin
		hit = 1'b0;
		status = axt_pkg::STATUS_NONE;
		value = '0;
		if (!hit_seen_q) begin
			if (!is_adrp && rd == target_reg_q) begin
				if (target_value_q == '0) begin
					hit = 1'b1;
					value = check_val;
				end else if (check_val == target_value_q) begin
					hit = 1'b1;
					value = pc_s1;
				end
			end
			if (hit) begin
				status = axt_pkg::STATUS_HIT;
			end else if (last_s1) begin
				status = axt_pkg::STATUS_END;
			end
		end
	end

	// Register file memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			reg_mem[rd] <= new_val;
		end
		if (accept) begin
			rn_rd_s1 <= reg_mem[rn_in];
			rd_rd_s1 <= reg_mem[item.insn[4:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			insn_s1 <= item.insn;
			pc_s1 <= item.pc;
			last_s1 <= item.last;
			rn_fwd_s1 <= mem_we && (rd == rn_in);
			rd_fwd_s1 <= mem_we && (rd == item.insn[4:0]);
			fwd_data_s1 <= new_val;
		end
		if (s1_adv) begin
			out_status_q <= status;
			out_value_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_v_q <= 1'b0;
			valid_q <= '0;
			hit_seen_q <= 1'b0;
			target_reg_q <= '0;
			target_value_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_adv) begin
				v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			if (s1_adv) begin
				if (last_s1) begin
					valid_q <= '0;
					hit_seen_q <= 1'b0;
				end else if (!hit_seen_q) begin
					if (is_ret) begin
						valid_q <= '0;
					end else if (do_wr) begin
						valid_q[rd] <= 1'b1;
					end
					if (hit) begin
						hit_seen_q <= 1'b1;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					axt_pkg::CFG_TARGET_REG: target_reg_q <= cfg.data[axt_pkg::REG_IDX_W-1:0];
					axt_pkg::CFG_TARGET_VALUE: target_value_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	assign result.valid = out_v_q;
	assign result.status = out_status_q;
	assign result.value = out_value_q;

`ifndef SYNTHESIS
	// A result that is not a hit always carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_status_q != axt_pkg::STATUS_HIT) |-> (out_value_q == '0))
		else $error("non-hit result carries a nonzero value");

	// A hit before the end of the scan suppresses the following items.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && hit && !last_s1) |=> hit_seen_q)
		else $error("hit flag not set after a hit");

	// The end of a scan empties the register file and the hit flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && last_s1) |=> (valid_q == '0 && !hit_seen_q))
		else $error("tracked state not cleared at end of scan");

	// Once a hit is seen, the register file is not written.
	assert property (@(posedge clk) disable iff (!arst_n)
		hit_seen_q |-> !mem_we)
		else $error("register file written after a hit");
`endif

endmodule
